// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during rst_ni low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every rising clock edge
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// check that a condition implies another one in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// check that a condition implies another one in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/skv_pkg.sv =====
// ----------------------------------------------------------------------------
// skv_pkg
// Sizes, codes and shared types of the sorted key/value table.
// ----------------------------------------------------------------------------
package skv_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BITS    = 64;
  localparam int DATA_W      = 64;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 6;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MV_HOLD,
    MV_NEW,
    MV_PREV,
    MV_NEXT
  } mv_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PRI,
    S_EXEC,
    S_EMIT,
    S_LIST
  } fsm_e;

  typedef struct packed {
    logic cmp_en;
    mv_e  mv;
  } cell_ctl_t;

endpackage

// ===== rtl/skv_cell.sv =====
// ----------------------------------------------------------------------------
// skv_cell
// One table slot: holds a key/value pair, compares it against the request
// key and loads from the request or from either neighbor.
// ----------------------------------------------------------------------------
module skv_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skv_pkg::cell_ctl_t          ctl_i,
  input  logic                        occ_i,
  input  logic [skv_pkg::KEY_BITS-1:0] new_key_i,
  input  logic [skv_pkg::DATA_W-1:0]   new_val_i,
  input  logic [skv_pkg::KEY_BITS-1:0] prev_key_i,
  input  logic [skv_pkg::DATA_W-1:0]   prev_val_i,
  input  logic [skv_pkg::KEY_BITS-1:0] next_key_i,
  input  logic [skv_pkg::DATA_W-1:0]   next_val_i,
  output logic [skv_pkg::KEY_BITS-1:0] key_o,
  output logic [skv_pkg::DATA_W-1:0]   val_o,
  output logic                        eq_o,
  output logic                        gt_o
);
  import skv_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                eq_q, eq_d;
  logic                gt_q, gt_d;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    case (ctl_i.mv)
      MV_NEW: begin
        key_d = new_key_i;
        val_d = new_val_i;
      end
      MV_PREV: begin
        key_d = prev_key_i;
        val_d = prev_val_i;
      end
      MV_NEXT: begin
        key_d = next_key_i;
        val_d = next_val_i;
      end
      default: begin
        key_d = key_q;
        val_d = val_q;
      end
    endcase
  end

  always_comb begin
    eq_d = eq_q;
    gt_d = gt_q;
    if (ctl_i.cmp_en) begin
      eq_d = occ_i && (key_q == new_key_i);
      gt_d = occ_i && (key_q > new_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q <= 1'b0;
      gt_q <= 1'b0;
    end else begin
      eq_q <= eq_d;
      gt_q <= gt_d;
    end
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign eq_o  = eq_q;
  assign gt_o  = gt_q;

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// Add, find, delete: states S_CMP, S_PRI, S_EXEC, S_EMIT; next request only back in S_IDLE.
// List: entries come from slot 0, one entry per cycle while the output is not stalled; the row
//   rotates through all TABLE_DEPTH slots before the block returns to S_IDLE.
// Empty list: one result, same timing as add.
// Reset clears the entry count and control at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order in a row of slot cells that
// shift toward either neighbor on insert, delete and list.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_value_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [skv_pkg::CMD_W-1:0]    cmd_i,
  input  logic [skv_pkg::DATA_W-1:0]   key_i,
  input  logic [skv_pkg::DATA_W-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [skv_pkg::STATUS_W-1:0] status_o,
  output logic [skv_pkg::DATA_W-1:0]   out_key_o,
  output logic [skv_pkg::DATA_W-1:0]   out_value_o,
  output logic [skv_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         last_o
);
  import skv_pkg::*;

  fsm_e st_q, st_d;

  cmd_e                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [DATA_W-1:0]   val_q;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] first_q;
  logic                hit_q;
  status_e             res_status_q;
  logic [DATA_W-1:0]   res_value_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [DATA_W-1:0]   out_key_q;
  logic [DATA_W-1:0]   out_value_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_last_q;

  logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
  logic [DATA_W-1:0]      cell_val [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [TABLE_DEPTH-1:0] cell_gt;
  logic [TABLE_DEPTH-1:0] cell_occ;
  logic [TABLE_DEPTH-1:0] gt_prev;
  logic [TABLE_DEPTH-1:0] after_match;
  cell_ctl_t              cell_ctl [TABLE_DEPTH];

  logic in_fire, out_free;
  logic cmp_en, pri_en, load_res, emit_res, emit_list;
  logic do_add, do_del, do_rot;
  logic table_full, list_more, list_end;
  logic [DATA_W-1:0] found_val;
  status_e res_status_d;
  logic [DATA_W-1:0] res_value_d;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (fill_q == FILL_W'(TABLE_DEPTH));
  assign list_more  = (FILL_W'(cnt_q) < fill_q);
  assign list_end   = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    pri_en     = 1'b0;
    load_res   = 1'b0;
    emit_res   = 1'b0;
    emit_list  = 1'b0;
    do_add     = 1'b0;
    do_del     = 1'b0;
    do_rot     = 1'b0;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    unique case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          if ((cmd_e'(cmd_i) == CMD_LIST) && (fill_q != '0)) begin
            st_d = S_LIST;
          end else begin
            st_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmp_en = 1'b1;
        st_d   = S_PRI;
      end
      S_PRI: begin
        pri_en = 1'b1;
        st_d   = S_EXEC;
      end
      S_EXEC: begin
        load_res = 1'b1;
        if ((cmd_q == CMD_ADD) && !table_full) begin
          do_add = 1'b1;
          fill_d = fill_q + FILL_W'(1);
        end
        if ((cmd_q == CMD_DELETE) && hit_q) begin
          do_del = 1'b1;
          fill_d = fill_q - FILL_W'(1);
        end
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_res = 1'b1;
          st_d     = S_IDLE;
        end
      end
      S_LIST: begin
        if (!list_more || out_free) begin
          emit_list = list_more;
          do_rot    = 1'b1;
          cnt_d     = cnt_q + IDX_W'(1);
          if (list_end) begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // first match and everything at or after it
  assign after_match = ~(first_q - TABLE_DEPTH'(1));
  assign gt_prev     = {cell_gt[TABLE_DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_occ[i]        = (FILL_W'(i) < fill_q);
      cell_ctl[i].cmp_en = cmp_en;
      cell_ctl[i].mv     = MV_HOLD;
      if (do_add && (cell_gt[i] || (FILL_W'(i) == fill_q))) begin
        cell_ctl[i].mv = gt_prev[i] ? MV_PREV : MV_NEW;
      end
      if ((do_del && after_match[i]) || do_rot) begin
        cell_ctl[i].mv = MV_NEXT;
      end
    end
  end

  always_comb begin
    found_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_val = found_val | (first_q[i] ? cell_val[i] : '0);
    end
  end

  always_comb begin
    res_status_d = ST_DONE;
    res_value_d  = '0;
    case (cmd_q)
      CMD_ADD: begin
        if (table_full) begin
          res_status_d = ST_FULL;
        end
      end
      CMD_FIND: begin
        if (hit_q) begin
          res_value_d = found_val;
        end else begin
          res_status_d = ST_MISS;
        end
      end
      CMD_DELETE: begin
        if (!hit_q) begin
          res_status_d = ST_MISS;
        end
      end
      default: res_status_d = ST_DONE;
    endcase
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int Prev = (g + TABLE_DEPTH - 1) % TABLE_DEPTH;
    localparam int Next = (g + 1) % TABLE_DEPTH;
    skv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[g]),
      .occ_i      (cell_occ[g]),
      .new_key_i  (key_q),
      .new_val_i  (val_q),
      .prev_key_i (cell_key[Prev]),
      .prev_val_i (cell_val[Prev]),
      .next_key_i (cell_key[Next]),
      .next_val_i (cell_val[Next]),
      .key_o      (cell_key[g]),
      .val_o      (cell_val[g]),
      .eq_o       (cell_eq[g]),
      .gt_o       (cell_gt[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i[KEY_BITS-1:0];
      val_q <= value_i;
    end
    if (load_res) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
    end
    if (emit_res) begin
      out_status_q <= res_status_q;
      out_key_q    <= DATA_W'(key_q);
      out_value_q  <= res_value_q;
      out_count_q  <= COUNT_W'(fill_q);
      out_last_q   <= 1'b1;
    end else if (emit_list) begin
      out_status_q <= ST_DONE;
      out_key_q    <= DATA_W'(cell_key[0]);
      out_value_q  <= cell_val[0];
      out_count_q  <= COUNT_W'(fill_q);
      out_last_q   <= ((FILL_W'(cnt_q) + FILL_W'(1)) == fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cnt_q       <= '0;
      first_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      if (pri_en) begin
        first_q <= cell_eq & (~cell_eq + TABLE_DEPTH'(1));
        hit_q   <= |cell_eq;
      end
      if (emit_res || emit_list) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_key_o     = out_key_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(TABLE_DEPTH))
  `ASSERT_SAME(a_first_onehot, st_q == S_EXEC, $onehot0(first_q) && (hit_q == (first_q != '0)))
  `ASSERT_NEXT(a_fill_hold, st_q == S_CMP || st_q == S_PRI, $stable(fill_q))
  `ASSERT_NEXT(a_emit_done, st_q == S_EMIT && out_free, st_q == S_IDLE && out_valid_q)

endmodule

// ===== dv/sorted_key_value_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_test
// Self-checking bench for the sorted key/value table. A short directed
// sequence covers empty-table misses, extreme keys, duplicates and list; then
// rounds of random requests fill the table to capacity, hammer it while full
// and drain it to empty. A predictor tracks the sorted contents and every
// result is compared field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;
  import skv_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - KEY_BITS);

  localparam logic [DATA_W-1:0] KEY_M   = 64'h6d00_0000_0000_0000;
  localparam logic [DATA_W-1:0] KEY_ABC = 64'h6162_6300_0000_0000;
  localparam logic [DATA_W-1:0] KEY_ZZ  = 64'h7a7a_0000_0000_0000;
  localparam logic [DATA_W-1:0] VAL_1   = 64'h3100_0000_0000_0000;
  localparam logic [DATA_W-1:0] VAL_2   = 64'h3200_0000_0000_0000;
  localparam logic [DATA_W-1:0] VAL_X   = 64'h7800_0000_0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = {DATA_W{1'b1}};

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  typedef struct {
    status_e              status;
    logic [DATA_W-1:0]    key;
    logic [DATA_W-1:0]    value;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } table_result_t;

  typedef struct {
    cmd_e              cmd;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    bit                typed;
    table_result_t     result;
  } request_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      cmd_i         = '0;
  logic [DATA_W-1:0]     key_i         = '0;
  logic [DATA_W-1:0]     value_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [DATA_W-1:0]     out_key_o;
  logic [DATA_W-1:0]     out_value_o;
  logic [COUNT_W-1:0]    entry_count_o;
  logic                  last_o;

  logic [DATA_W-1:0] model_keys   [TABLE_DEPTH];
  logic [DATA_W-1:0] model_values [TABLE_DEPTH];
  int                model_fill   = 0;
  table_result_t     pending_results[$];
  int                errors       = 0;
  int                cycle_count  = 0;
  int                sent_random  = 0;
  bit                no_idle      = 1'b0;

  sorted_key_value_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void predict_command(cmd_e cmd, logic [DATA_W-1:0] key_in,
                                          logic [DATA_W-1:0] value_in);
    logic [DATA_W-1:0] k;
    int                pos;
    int                hit;
    table_result_t     r;
    k   = key_in & KEY_MASK;
    hit = -1;
    for (int i = 0; i < model_fill; i++) begin
      if (hit < 0 && model_keys[i] == k) hit = i;
    end
    r.status = ST_DONE;
    r.key    = k;
    r.value  = '0;
    r.last   = 1'b1;
    case (cmd)
      CMD_ADD: begin
        if (model_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = model_fill;
          while (pos > 0 && model_keys[pos-1] > k) begin
            model_keys[pos]   = model_keys[pos-1];
            model_values[pos] = model_values[pos-1];
            pos--;
          end
          model_keys[pos]   = k;
          model_values[pos] = value_in;
          model_fill++;
        end
      end
      CMD_FIND: begin
        if (hit < 0) r.status = ST_MISS;
        else r.value = model_values[hit];
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          for (int j = hit; j < model_fill - 1; j++) begin
            model_keys[j]   = model_keys[j+1];
            model_values[j] = model_values[j+1];
          end
          model_fill--;
        end
      end
      default: begin
        if (model_fill > 0) begin
          for (int i = 0; i < model_fill; i++) begin
            r.key   = model_keys[i];
            r.value = model_values[i];
            r.count = model_fill[COUNT_W-1:0];
            r.last  = (i == model_fill - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.count = model_fill[COUNT_W-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic request_row_t make_row(cmd_e cmd, logic [DATA_W-1:0] key,
                                            logic [DATA_W-1:0] value, bit typed = 1'b0,
                                            status_e status = ST_DONE,
                                            logic [DATA_W-1:0] out_value = '0,
                                            int count = 0);
    request_row_t row;
    row.cmd          = cmd;
    row.key          = key;
    row.value        = value;
    row.typed        = typed;
    row.result.status = status;
    row.result.key   = key & KEY_MASK;
    row.result.value = out_value;
    row.result.count = count[COUNT_W-1:0];
    row.result.last  = 1'b1;
    return row;
  endfunction

  function automatic logic [DATA_W-1:0] ascii_word(logic [7:0] base, int span, int max_len);
    logic [DATA_W-1:0] word;
    int                len;
    len  = $urandom_range(1, max_len);
    word = '0;
    for (int i = 0; i < 8; i++) begin
      word = {word[DATA_W-9:0], (i < len) ? 8'(base + $urandom_range(0, span - 1)) : 8'h00};
    end
    return word;
  endfunction

  function automatic logic [DATA_W-1:0] pick_key(int hit_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (model_fill > 0 && roll < hit_pct) return model_keys[$urandom_range(0, model_fill - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 5) return ascii_word(8'h61, 4, 3);
    if (roll < 9) return {$urandom, $urandom};
    return $urandom_range(0, 1) ? ALL_ONE : '0;
  endfunction

  task automatic send_request(request_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= row.cmd;
    key_i      <= row.key;
    value_i    <= row.value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(row.cmd, row.key, row.value);
    if (row.typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(row.result);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  task automatic random_request(phase_e phase);
    request_row_t row;
    int           pick;
    pick = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  row.cmd = pick < 70 ? CMD_ADD : pick < 85 ? CMD_FIND :
                          pick < 95 ? CMD_DELETE : CMD_LIST;
      PH_DRAIN: row.cmd = pick < 70 ? CMD_DELETE : pick < 80 ? CMD_ADD :
                          pick < 95 ? CMD_FIND : CMD_LIST;
      default:  row.cmd = cmd_e'(pick % 4);
    endcase
    row.key   = pick_key(phase == PH_DRAIN ? 90 : 50);
    row.value = $urandom_range(0, 1) ? {$urandom, $urandom} : ascii_word(8'h30, 10, 8);
    row.typed = 1'b0;
    no_idle   = (sent_random % 64) < 16;
    send_request(row);
    sent_random++;
  endtask

  initial begin
    table_result_t want;
    int            stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, key %h value %h", $time, out_key_o, out_value_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (out_key_o !== want.key) begin
          errors++;
          $display("%0t: out_key expected %h actual %h", $time, want.key, out_key_o);
        end
        if (out_value_o !== want.value) begin
          errors++;
          $display("%0t: out_value expected %h actual %h", $time, want.value, out_value_o);
        end
        if (entry_count_o !== want.count) begin
          errors++;
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   entry_count_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  initial begin
    request_row_t dir_rows[$];
    dir_rows.push_back(make_row(CMD_LIST,   64'h0123_4567_89ab_cdef, '0, 1, ST_DONE, '0, 0));
    dir_rows.push_back(make_row(CMD_FIND,   '0,      '0,      1, ST_MISS, '0, 0));
    dir_rows.push_back(make_row(CMD_DELETE, ALL_ONE, ALL_ONE, 1, ST_MISS, '0, 0));
    dir_rows.push_back(make_row(CMD_ADD,    '0,      ALL_ONE, 1, ST_DONE, '0, 1));
    dir_rows.push_back(make_row(CMD_ADD,    ALL_ONE, '0,      1, ST_DONE, '0, 2));
    dir_rows.push_back(make_row(CMD_ADD,    KEY_M,   VAL_1,   1, ST_DONE, '0, 3));
    dir_rows.push_back(make_row(CMD_ADD,    KEY_M,   VAL_2,   1, ST_DONE, '0, 4));
    dir_rows.push_back(make_row(CMD_ADD,    KEY_ABC, VAL_X,   1, ST_DONE, '0, 5));
    dir_rows.push_back(make_row(CMD_FIND,   KEY_M,   '0));
    dir_rows.push_back(make_row(CMD_FIND,   ALL_ONE, ALL_ONE));
    dir_rows.push_back(make_row(CMD_FIND,   '0,      '0));
    dir_rows.push_back(make_row(CMD_LIST,   '0,      '0));
    dir_rows.push_back(make_row(CMD_DELETE, KEY_M,   '0,      1, ST_DONE, '0, 4));
    dir_rows.push_back(make_row(CMD_FIND,   KEY_M,   '0));
    dir_rows.push_back(make_row(CMD_DELETE, KEY_ZZ,  '0,      1, ST_MISS, '0, 4));
    dir_rows.push_back(make_row(CMD_DELETE, '0,      '0,      1, ST_DONE, '0, 3));
    dir_rows.push_back(make_row(CMD_LIST,   ALL_ONE, ALL_ONE));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      no_idle = (i % 8) < 3;
      send_request(dir_rows[i]);
    end
    drain_results();

    while (sent_random < RANDOM_ITEMS) begin
      while (model_fill < TABLE_DEPTH && sent_random < RANDOM_ITEMS) random_request(PH_FILL);
      repeat (12) random_request(PH_MIX);
      while (model_fill > 0 && sent_random < RANDOM_ITEMS) random_request(PH_DRAIN);
      repeat (6) random_request(PH_MIX);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_key_value_table.f =====
+incdir+rtl
rtl/skv_pkg.sv
rtl/skv_cell.sv
rtl/sorted_key_value_table.sv
dv/sorted_key_value_table_test.sv
